/* rtl/core/iaid_pkg.sv */
// Package: shared types, codes and constants of the indexed array list.
package iaid_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 4;
  localparam int WORD_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

endpackage

/* rtl/core/iaid_in_if.sv */
// Interface: command item channel.
interface iaid_in_if;
  logic                       valid;
  logic                       ready;
  logic [iaid_pkg::CMD_W-1:0]  cmd;
  logic [iaid_pkg::POS_W-1:0]  position;
  logic [iaid_pkg::WORD_W-1:0] word_in;

  modport source (output valid, output cmd, output position, output word_in, input ready);
  modport sink (input valid, input cmd, input position, input word_in, output ready);
endinterface

/* rtl/core/iaid_out_if.sv */
// Interface: result item channel.
interface iaid_out_if;
  logic                         valid;
  logic                         ready;
  logic [iaid_pkg::WORD_W-1:0]   word_out;
  logic [iaid_pkg::SLOT_W-1:0]   slot;
  logic [iaid_pkg::FILL_W-1:0]   fill;
  logic [iaid_pkg::STATUS_W-1:0] status;
  logic                         last;

  modport source (output valid, output word_out, output slot, output fill, output status,
                  output last, input ready);
  modport sink (input valid, input word_out, input slot, input fill, input status,
                input last, output ready);
endinterface

/* rtl/core/iaid_cell.sv */
// One storage cell of the list: holds one word and moves it with its neighbors.
module iaid_cell #(
  parameter int IDX       = 0,
  parameter int CNT_W     = 5,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  iaid_pkg::cell_op_t   op,
  input  logic [CNT_W-1:0]     pos,
  input  logic [CNT_W-1:0]     count,
  input  logic [WORD_BITS-1:0] word_new,
  input  logic [WORD_BITS-1:0] from_lower,
  input  logic [WORD_BITS-1:0] from_upper,
  input  logic [WORD_BITS-1:0] head,
  output logic [WORD_BITS-1:0] word
);
  import iaid_pkg::*;

  localparam logic [CNT_W-1:0] ME = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NX = CNT_W'(IDX + 1);

  logic [WORD_BITS-1:0] word_next;

  always_comb begin
    word_next = word;
    unique case (op)
      OP_APPEND: begin
        if (ME == count) word_next = word_new;
      end
      OP_INSERT: begin
        if (ME == pos) word_next = word_new;
        else if (ME > pos) word_next = from_lower;
      end
      OP_DELETE: begin
        if (ME >= pos) word_next = from_upper;
      end
      OP_ROTATE: begin
        if (NX == count) word_next = head;
        else if (NX < count) word_next = from_upper;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

/* rtl/core/indexed_array_insert_delete.sv */
// Top level: ordered word list with append, insert, delete and dump over a cell chain.
//
// Usage: commands arrive on req (cmd, position, word_in) and results leave on rsp
// (word_out, slot, fill, status, last), both valid/ready channels.
// Append, insert and delete each give one result carrying a status and the new
// fill; the result sits in the rsp output register in the cycle after the command
// is taken. Insert and delete shift all later cells by one in the same cycle as
// that register load, since every cell loads from its neighbor in parallel.
// Dump first enters its dump state, then gives one result per stored word, read
// from cell 0 while the chain rotates by one position; after the last word the
// list is back in order. An empty list dumps as one result with status empty.
// req.ready is low during a dump, and low while a result waits in the output
// register and rsp.ready is low, so a stalled receiver holds the whole block.
// Throughput: one edit per cycle when rsp is not stalled.
// Reset clears the count and the control state; cell contents are not cleared.
module indexed_array_insert_delete #(
  parameter int CAPACITY  = iaid_pkg::CAPACITY_DEF,
  parameter int WORD_BITS = iaid_pkg::WORD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  iaid_in_if.sink    req,
  iaid_out_if.source rsp
);
  import iaid_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_t                 state, state_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [CNT_W-1:0]       k, k_next;
  logic [CNT_W-1:0]       k_nx;
  cell_op_t               op;
  logic                   out_free;
  logic                   load;
  logic                   full;
  logic [CMP_W-1:0]       pos_w;
  logic [CMP_W-1:0]       cnt_w;
  logic [WORD_BITS-1:0]   word_new;
  logic [63:0]            win_ext;
  logic [63:0]            head_ext;
  logic [7:0]             slot_ext;
  logic [7:0]             fill_ext;
  logic [WORD_W-1:0]      o_word;
  logic [SLOT_W-1:0]      o_slot;
  logic [STATUS_W-1:0]    o_status;
  logic                   o_last;

  logic                   rsp_valid;
  logic [WORD_W-1:0]      rsp_word;
  logic [SLOT_W-1:0]      rsp_slot;
  logic [FILL_W-1:0]      rsp_fill;
  logic [STATUS_W-1:0]    rsp_status;
  logic                   rsp_last;

  logic [WORD_BITS-1:0]   cells   [CAPACITY];
  logic [WORD_BITS-1:0]   lower_w [CAPACITY];
  logic [WORD_BITS-1:0]   upper_w [CAPACITY];

  assign win_ext  = 64'(req.word_in);
  assign word_new = win_ext[WORD_BITS-1:0];
  assign head_ext = 64'(cells[0]);
  assign pos_w    = CMP_W'(req.position);
  assign cnt_w    = CMP_W'(count);
  assign full     = (count == CNT_W'(CAPACITY));
  assign k_nx     = k + CNT_W'(1);
  assign out_free = !rsp_valid || rsp.ready;
  assign slot_ext = 8'(k);
  assign fill_ext = 8'(count_next);

  assign req.ready = (state == S_IDLE) && out_free;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_chain
      if (g == 0) begin : g_first
        assign lower_w[g] = '0;
      end else begin : g_mid_lo
        assign lower_w[g] = cells[g-1];
      end
      if (g == CAPACITY - 1) begin : g_end
        assign upper_w[g] = '0;
      end else begin : g_mid_hi
        assign upper_w[g] = cells[g+1];
      end

      iaid_cell #(
        .IDX       (g),
        .CNT_W     (CNT_W),
        .WORD_BITS (WORD_BITS)
      ) u_cell (
        .clk        (clk),
        .op         (op),
        .pos        (CNT_W'(pos_w)),
        .count      (count),
        .word_new   (word_new),
        .from_lower (lower_w[g]),
        .from_upper (upper_w[g]),
        .head       (cells[0]),
        .word       (cells[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    k_next     = k;
    op         = OP_HOLD;
    load       = 1'b0;
    o_word     = '0;
    o_slot     = '0;
    o_status   = ST_OK;
    o_last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          unique case (req.cmd)
            CMD_APPEND: begin
              load = 1'b1;
              if (full) begin
                o_status = ST_FULL;
              end else begin
                op         = OP_APPEND;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_INSERT: begin
              load = 1'b1;
              if (pos_w > cnt_w) begin
                o_status = ST_RANGE;
              end else if (full) begin
                o_status = ST_FULL;
              end else begin
                op         = OP_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              load = 1'b1;
              if (count == '0) begin
                o_status = ST_EMPTY;
              end else if (pos_w >= cnt_w) begin
                o_status = ST_RANGE;
              end else begin
                op         = OP_DELETE;
                count_next = count - CNT_W'(1);
              end
            end
            CMD_DUMP: begin
              if (count == '0) begin
                load     = 1'b1;
                o_status = ST_EMPTY;
              end else begin
                state_next = S_DUMP;
                k_next     = '0;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          load   = 1'b1;
          op     = OP_ROTATE;
          o_word = head_ext[WORD_W-1:0];
          o_slot = slot_ext[SLOT_W-1:0];
          o_last = (k_nx == count);
          k_next = k_nx;
          if (k_nx == count) state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_word   <= o_word;
      rsp_slot   <= o_slot;
      rsp_fill   <= fill_ext[FILL_W-1:0];
      rsp_status <= o_status;
      rsp_last   <= o_last;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.word_out = rsp_word;
  assign rsp.slot     = rsp_slot;
  assign rsp.fill     = rsp_fill;
  assign rsp.status   = rsp_status;
  assign rsp.last     = rsp_last;

endmodule

/* bench/tb_top.sv */
// Testbench for the indexed array list: directed and random commands checked against a shadow list.
`timescale 1ns / 100ps

module tb_top;
  import iaid_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [SLOT_W-1:0]   slot;
    logic [FILL_W-1:0]   fill;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [WORD_W-1:0] shadow_words[$];
  rsp_item_t         rsp_due[$];
  int                mismatches = 0;
  bit                steady = 1'b0;

  iaid_in_if  req_if ();
  iaid_out_if rsp_if ();

  indexed_array_insert_delete uut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 14);
  endfunction

  // Shadow list update; queues the results the command should produce.
  function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                        input logic [POS_W-1:0] pos,
                                        input logic [WORD_W-1:0] word);
    rsp_item_t r;
    int n;
    n = shadow_words.size();
    r = '0;
    r.last = 1'b1;
    r.status = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        if (n >= CAPACITY_DEF) r.status = ST_FULL;
        else shadow_words.push_back(word);
      end
      CMD_INSERT: begin
        if (int'(pos) > n) r.status = ST_RANGE;
        else if (n >= CAPACITY_DEF) r.status = ST_FULL;
        else shadow_words.insert(int'(pos), word);
      end
      CMD_DELETE: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (int'(pos) >= n) r.status = ST_RANGE;
        else shadow_words.delete(int'(pos));
      end
      default: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < n; i++) begin
            r.word = shadow_words[i];
            r.slot = SLOT_W'(i);
            r.fill = FILL_W'(n);
            r.last = (i == n - 1);
            rsp_due.push_back(r);
          end
          return;
        end
      end
    endcase
    r.fill = FILL_W'(shadow_words.size());
    rsp_due.push_back(r);
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic [WORD_W-1:0] word);
    while (idle_now()) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.cmd      <= cmd;
    req_if.position <= pos;
    req_if.word_in  <= word;
    @(negedge clk);
    while (!req_if.ready) @(negedge clk);
    @(posedge clk);
    apply_command(cmd, pos, word);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) rsp_if.ready <= steady || ($urandom_range(99) >= 14);

  always @(negedge clk) begin : check_rsp
    rsp_item_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (rsp_due.size() == 0) begin
        $error("unexpected item: word_out=%h fill=%0d status=%0d",
               rsp_if.word_out, rsp_if.fill, rsp_if.status);
        mismatches++;
      end else begin
        want = rsp_due.pop_front();
        if (rsp_if.word_out !== want.word) begin
          $error("word_out: expected %h, got %h", want.word, rsp_if.word_out);
          mismatches++;
        end
        if (rsp_if.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, rsp_if.slot);
          mismatches++;
        end
        if (rsp_if.fill !== want.fill) begin
          $error("fill: expected %0d, got %0d", want.fill, rsp_if.fill);
          mismatches++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, rsp_if.last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_cmd(CMD_DUMP, 4'd0, 32'd0);
    send_cmd(CMD_DELETE, 4'd0, 32'd0);
    send_cmd(CMD_INSERT, 4'd1, 32'h1234_5678);
    send_cmd(CMD_INSERT, 4'd0, 32'hFFFF_FFFF);
    send_cmd(CMD_DELETE, 4'd1, 32'd0);
  endtask

  task automatic test_fill_to_capacity();
    send_cmd(CMD_INSERT, 4'd0, 32'd0);
    while (shadow_words.size() < CAPACITY_DEF)
      send_cmd(CMD_APPEND, POS_W'($urandom_range(15)), $urandom);
    send_cmd(CMD_APPEND, 4'd9, 32'hDEAD_BEEF);
    send_cmd(CMD_INSERT, 4'd15, 32'hCAFE_F00D);
    send_cmd(CMD_DUMP, 4'd15, 32'hFFFF_FFFF);
  endtask

  task automatic test_edits_at_ends();
    send_cmd(CMD_DELETE, 4'd15, $urandom);
    send_cmd(CMD_DELETE, 4'd0, $urandom);
    send_cmd(CMD_DELETE, 4'd14, $urandom);
    send_cmd(CMD_INSERT, 4'd14, $urandom);
    send_cmd(CMD_DUMP, 4'd0, 32'd0);
  endtask

  task automatic test_random_mix();
    int r, n, a_lim, i_lim, d_lim;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    for (int k = 0; k < 300; k++) begin
      steady = (k >= 120 && k < 200);
      if (k == 150) wait_drained();
      if (k < 100) begin
        a_lim = 35; i_lim = 70; d_lim = 88;
      end else if (k < 200) begin
        a_lim = 20; i_lim = 40; d_lim = 85;
      end else begin
        a_lim = 25; i_lim = 50; d_lim = 80;
      end
      n = shadow_words.size();
      r = $urandom_range(99);
      pos = POS_W'($urandom_range(15));
      if (r < a_lim) begin
        cmd = CMD_APPEND;
      end else if (r < i_lim) begin
        cmd = CMD_INSERT;
        if ($urandom_range(9) != 0 && n <= 15) pos = POS_W'($urandom_range(n));
      end else if (r < d_lim) begin
        cmd = CMD_DELETE;
        if ($urandom_range(9) != 0 && n > 0) pos = POS_W'($urandom_range(n - 1));
      end else begin
        cmd = CMD_DUMP;
      end
      send_cmd(cmd, pos, $urandom);
    end
    steady = 1'b0;
  endtask

  initial begin
    req_if.valid    = 1'b0;
    req_if.cmd      = CMD_APPEND;
    req_if.position = '0;
    req_if.word_in  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_to_capacity();
    test_edits_at_ends();
    wait_drained();
    test_random_mix();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/iaid_pkg.sv
rtl/core/iaid_in_if.sv
rtl/core/iaid_out_if.sv
rtl/core/iaid_cell.sv
rtl/core/indexed_array_insert_delete.sv
bench/tb_top.sv
